### rtl/core/polar_vector_adder_assert.svh
// Assertion macros for the polar vector adder RTL.
`ifndef POLAR_VECTOR_ADDER_ASSERT_SVH
`define POLAR_VECTOR_ADDER_ASSERT_SVH

// Same-cycle implication, sampled on i_clk and disabled during reset.
`define PVA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and disabled during reset.
`define PVA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/pva_pkg.sv
// Package with the widths, payload types and constants of the polar vector adder.
package pva_pkg;

    localparam int RADIUS_BITS   = 24;
    localparam int DIR_FRAC_BITS = 14;
    localparam int DIR_W         = DIR_FRAC_BITS + 2;
    localparam int MAG_W         = RADIUS_BITS + DIR_FRAC_BITS + 2;
    localparam int PROD_W        = MAG_W + 1;
    localparam int HALF_W        = (MAG_W + 1) / 2;
    localparam int HIGH_W        = MAG_W - HALF_W;
    localparam int FULL_W        = 2 * MAG_W + 2;
    localparam int ROOT_W        = RADIUS_BITS + 3;
    localparam int SQ_W          = 2 * ROOT_W;
    localparam int REM_W         = ROOT_W + 1;
    localparam int QUO_W         = DIR_FRAC_BITS + 1;
    localparam int OUT_RAD_W     = RADIUS_BITS + 1;
    localparam int DIR_ONE       = 1 << DIR_FRAC_BITS;
    localparam int THR_W         = 8;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int APB_AW        = 3;
    localparam int APB_DW        = 32;

    localparam logic             REG_ZERO_THRESHOLD = 1'b0;
    localparam logic [THR_W-1:0] THR_RESET          = THR_W'(1);

    typedef struct packed {
        logic [RADIUS_BITS-1:0]  a_radius;
        logic signed [DIR_W-1:0] a_dir_x;
        logic signed [DIR_W-1:0] a_dir_y;
        logic [RADIUS_BITS-1:0]  b_radius;
        logic signed [DIR_W-1:0] b_dir_x;
        logic signed [DIR_W-1:0] b_dir_y;
    } t_req;

    typedef struct packed {
        logic [OUT_RAD_W-1:0]    sum_radius;
        logic signed [DIR_W-1:0] sum_dir_x;
        logic signed [DIR_W-1:0] sum_dir_y;
        logic                    is_zero;
    } t_res;

    typedef struct packed {
        logic             x_neg;
        logic [MAG_W-1:0] x_mag;
        logic             y_neg;
        logic [MAG_W-1:0] y_mag;
    } t_vec;

endpackage

### rtl/core/pva_front.sv
// Front part: accepts requests, scales both directions and forms the cartesian sum.
module pva_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  pva_pkg::t_req i_req,
    output logic          o_vec_valid,
    input  logic          i_vec_ready,
    output pva_pkg::t_vec o_vec
);
    import pva_pkg::*;

    logic                     r_valid;
    logic signed [PROD_W-1:0] r_ax;
    logic signed [PROD_W-1:0] r_bx;
    logic signed [PROD_W-1:0] r_ay;
    logic signed [PROD_W-1:0] r_by;
    logic [PROD_W:0]          sum_x;
    logic [PROD_W:0]          sum_y;
    logic [PROD_W:0]          abs_x;
    logic [PROD_W:0]          abs_y;
    logic                     take;

    assign full = r_valid && !i_vec_ready;
    assign take = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!full) begin
            r_valid <= push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_ax <= $signed({1'b0, i_req.a_radius}) * i_req.a_dir_x;
            r_bx <= $signed({1'b0, i_req.b_radius}) * i_req.b_dir_x;
            r_ay <= $signed({1'b0, i_req.a_radius}) * i_req.a_dir_y;
            r_by <= $signed({1'b0, i_req.b_radius}) * i_req.b_dir_y;
        end
    end

    always_comb begin
        sum_x = {r_ax[PROD_W-1], r_ax} + {r_bx[PROD_W-1], r_bx};
        sum_y = {r_ay[PROD_W-1], r_ay} + {r_by[PROD_W-1], r_by};
        abs_x = sum_x[PROD_W] ? (~sum_x + 1'b1) : sum_x;
        abs_y = sum_y[PROD_W] ? (~sum_y + 1'b1) : sum_y;
        o_vec.x_neg = sum_x[PROD_W];
        o_vec.x_mag = abs_x[MAG_W-1:0];
        o_vec.y_neg = sum_y[PROD_W];
        o_vec.y_mag = abs_y[MAG_W-1:0];
    end

    assign o_vec_valid = r_valid;

endmodule

### rtl/core/pva_queue.sv
// Short queue that decouples the front part from the back part.
module pva_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  pva_pkg::t_vec i_data,
    output logic          o_not_full,
    input  logic          i_rd,
    output logic          o_not_empty,
    output pva_pkg::t_vec o_data
);
    import pva_pkg::*;

    t_vec              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    logic              do_wr;
    logic              do_rd;

    assign o_not_full  = r_count != (QPTR_W + 1)'(QUEUE_DEPTH);
    assign o_not_empty = r_count != '0;
    assign do_wr       = i_wr && o_not_full;
    assign do_rd       = i_rd && o_not_empty;
    assign o_data      = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

### rtl/core/pva_back.sv
// Back part: squares, root, division pipeline and the result register.
module pva_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_vec_valid,
    output logic                      o_vec_ready,
    input  pva_pkg::t_vec             i_vec,
    input  logic [pva_pkg::THR_W-1:0] i_threshold,
    output logic                      empty,
    input  logic                      pop,
    output pva_pkg::t_res             o_res
);
    import pva_pkg::*;

    `include "polar_vector_adder_assert.svh"

    logic en;

    logic                      r_a_valid;
    t_vec                      r_a_vec;
    logic [2*HIGH_W-1:0]       r_a_xhh;
    logic [HIGH_W+HALF_W-1:0]  r_a_xhl;
    logic [2*HALF_W-1:0]       r_a_xll;
    logic [2*HIGH_W-1:0]       r_a_yhh;
    logic [HIGH_W+HALF_W-1:0]  r_a_yhl;
    logic [2*HALF_W-1:0]       r_a_yll;

    logic [FULL_W-1:0] tot;
    logic              r_b_valid;
    t_vec              r_b_vec;
    logic [SQ_W-1:0]   r_b_s;

    logic [ROOT_W-1:0] r_sq_valid;
    logic [REM_W-1:0]  r_sq_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_sq_root [ROOT_W];
    logic [SQ_W-1:0]   r_sq_s    [ROOT_W];
    t_vec              r_sq_vec  [ROOT_W];

    logic [QUO_W-1:0]  r_dv_valid;
    logic [ROOT_W-1:0] r_dv_root [QUO_W];
    t_vec              r_dv_vec  [QUO_W];
    logic [ROOT_W-1:0] r_dv_xr   [QUO_W];
    logic [ROOT_W-1:0] r_dv_yr   [QUO_W];
    logic [QUO_W-1:0]  r_dv_xq   [QUO_W];
    logic [QUO_W-1:0]  r_dv_yq   [QUO_W];

    logic              r_out_valid;
    t_res              r_out;
    t_res              n_out;
    logic [QUO_W-1:0]  clamp_x;
    logic [QUO_W-1:0]  clamp_y;
    logic [ROOT_W-1:0] fin_root;

    assign en          = !r_out_valid || pop;
    assign o_vec_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= i_vec_valid;
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_vec <= i_vec;
            r_a_xhh <= i_vec.x_mag[MAG_W-1:HALF_W] * i_vec.x_mag[MAG_W-1:HALF_W];
            r_a_xhl <= i_vec.x_mag[MAG_W-1:HALF_W] * i_vec.x_mag[HALF_W-1:0];
            r_a_xll <= i_vec.x_mag[HALF_W-1:0] * i_vec.x_mag[HALF_W-1:0];
            r_a_yhh <= i_vec.y_mag[MAG_W-1:HALF_W] * i_vec.y_mag[MAG_W-1:HALF_W];
            r_a_yhl <= i_vec.y_mag[MAG_W-1:HALF_W] * i_vec.y_mag[HALF_W-1:0];
            r_a_yll <= i_vec.y_mag[HALF_W-1:0] * i_vec.y_mag[HALF_W-1:0];
            r_b_vec <= r_a_vec;
            r_b_s   <= SQ_W'(tot >> (2 * DIR_FRAC_BITS));
        end
    end

    always_comb begin
        tot = (FULL_W'(r_a_xhh) << (2 * HALF_W)) + (FULL_W'(r_a_xhl) << (HALF_W + 1))
            + FULL_W'(r_a_xll)
            + (FULL_W'(r_a_yhh) << (2 * HALF_W)) + (FULL_W'(r_a_yhl) << (HALF_W + 1))
            + FULL_W'(r_a_yll);
    end

    for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
        logic              s_valid;
        logic [REM_W-1:0]  s_rem;
        logic [ROOT_W-1:0] s_root;
        logic [SQ_W-1:0]   s_s;
        t_vec              s_vec;
        logic [REM_W+1:0]  cur;
        logic [REM_W+1:0]  trial;
        logic              ge;

        if (k == 0) begin : g_first
            assign s_valid = r_b_valid;
            assign s_rem   = '0;
            assign s_root  = '0;
            assign s_s     = r_b_s;
            assign s_vec   = r_b_vec;
        end else begin : g_next
            assign s_valid = r_sq_valid[k-1];
            assign s_rem   = r_sq_rem[k-1];
            assign s_root  = r_sq_root[k-1];
            assign s_s     = r_sq_s[k-1];
            assign s_vec   = r_sq_vec[k-1];
        end

        assign cur   = {s_rem, s_s[SQ_W-1-2*k -: 2]};
        assign trial = {1'b0, s_root, 2'b01};
        assign ge    = cur >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_valid[k] <= 1'b0;
            end else if (en) begin
                r_sq_valid[k] <= s_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sq_rem[k]  <= ge ? REM_W'(cur - trial) : REM_W'(cur);
                r_sq_root[k] <= {s_root[ROOT_W-2:0], ge};
                r_sq_s[k]    <= s_s;
                r_sq_vec[k]  <= s_vec;
            end
        end
    end

    for (genvar j = 0; j < QUO_W; j++) begin : g_div
        logic              d_valid;
        logic [ROOT_W-1:0] d_root;
        t_vec              d_vec;
        logic [ROOT_W-1:0] d_xr;
        logic [ROOT_W-1:0] d_yr;
        logic [QUO_W-1:0]  d_xq;
        logic [QUO_W-1:0]  d_yq;
        logic [ROOT_W:0]   cur_x;
        logic [ROOT_W:0]   cur_y;
        logic              ge_x;
        logic              ge_y;

        if (j == 0) begin : g_first
            assign d_valid = r_sq_valid[ROOT_W-1];
            assign d_root  = r_sq_root[ROOT_W-1];
            assign d_vec   = r_sq_vec[ROOT_W-1];
            assign d_xr    = ROOT_W'(r_sq_vec[ROOT_W-1].x_mag >> QUO_W);
            assign d_yr    = ROOT_W'(r_sq_vec[ROOT_W-1].y_mag >> QUO_W);
            assign d_xq    = '0;
            assign d_yq    = '0;
        end else begin : g_next
            assign d_valid = r_dv_valid[j-1];
            assign d_root  = r_dv_root[j-1];
            assign d_vec   = r_dv_vec[j-1];
            assign d_xr    = r_dv_xr[j-1];
            assign d_yr    = r_dv_yr[j-1];
            assign d_xq    = r_dv_xq[j-1];
            assign d_yq    = r_dv_yq[j-1];
        end

        assign cur_x = {d_xr, d_vec.x_mag[QUO_W-1-j]};
        assign cur_y = {d_yr, d_vec.y_mag[QUO_W-1-j]};
        assign ge_x  = cur_x >= {1'b0, d_root};
        assign ge_y  = cur_y >= {1'b0, d_root};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_valid[j] <= 1'b0;
            end else if (en) begin
                r_dv_valid[j] <= d_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv_root[j] <= d_root;
                r_dv_vec[j]  <= d_vec;
                r_dv_xr[j]   <= ge_x ? ROOT_W'(cur_x - {1'b0, d_root}) : ROOT_W'(cur_x);
                r_dv_yr[j]   <= ge_y ? ROOT_W'(cur_y - {1'b0, d_root}) : ROOT_W'(cur_y);
                r_dv_xq[j]   <= {d_xq[QUO_W-2:0], ge_x};
                r_dv_yq[j]   <= {d_yq[QUO_W-2:0], ge_y};
            end
        end
    end

    always_comb begin
        fin_root = r_dv_root[QUO_W-1];
        clamp_x  = (r_dv_xq[QUO_W-1] > QUO_W'(DIR_ONE)) ? QUO_W'(DIR_ONE) : r_dv_xq[QUO_W-1];
        clamp_y  = (r_dv_yq[QUO_W-1] > QUO_W'(DIR_ONE)) ? QUO_W'(DIR_ONE) : r_dv_yq[QUO_W-1];
        if (fin_root <= ROOT_W'(i_threshold)) begin
            n_out.sum_radius = '0;
            n_out.sum_dir_x  = '0;
            n_out.sum_dir_y  = '0;
            n_out.is_zero    = 1'b1;
        end else begin
            n_out.sum_radius = (|fin_root[ROOT_W-1:OUT_RAD_W]) ? '1
                                                               : fin_root[OUT_RAD_W-1:0];
            n_out.sum_dir_x  = r_dv_vec[QUO_W-1].x_neg ? -DIR_W'(clamp_x) : DIR_W'(clamp_x);
            n_out.sum_dir_y  = r_dv_vec[QUO_W-1].y_neg ? -DIR_W'(clamp_y) : DIR_W'(clamp_y);
            n_out.is_zero    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_dv_valid[QUO_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign empty = !r_out_valid;
    assign o_res = r_out;

    `PVA_ASSERT_NOW(a_zero_result_clear, r_out_valid && r_out.is_zero,
        r_out.sum_radius == '0 && r_out.sum_dir_x == '0 && r_out.sum_dir_y == '0,
        "A zero result carries a non-zero payload.")
    `PVA_ASSERT_NEXT(a_result_held, r_out_valid && !pop,
        r_out_valid && $stable(r_out), "A waiting result changed before it was taken.")
    `PVA_ASSERT_NOW(a_dir_in_range, r_out_valid,
        r_out.sum_dir_x <= DIR_ONE && r_out.sum_dir_x >= -DIR_ONE
        && r_out.sum_dir_y <= DIR_ONE && r_out.sum_dir_y >= -DIR_ONE,
        "A result direction lies outside plus or minus one.")

endmodule

### rtl/core/polar_vector_adder.sv
// Throughput: one request per cycle unless a waiting result stalls; the root takes one bit per
// stage (27 stages) and the direction divide one quotient bit per stage (15 stages), fully pipelined.
// A waiting result stalls the whole back pipeline; the front queue keeps accepting until full.
// Reset is synchronous and active low: all pipeline and queue state empties and
// zero_threshold returns to 1.
module polar_vector_adder (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       push,
    output logic                       full,
    input  pva_pkg::t_req              i_req,
    output logic                       empty,
    input  logic                       pop,
    output pva_pkg::t_res              o_res,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [pva_pkg::APB_AW-1:0] paddr,
    input  logic [pva_pkg::APB_DW-1:0] pwdata,
    output logic [pva_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);
    import pva_pkg::*;

    logic [THR_W-1:0] r_zero_threshold;
    logic             front_valid;
    t_vec             front_vec;
    logic             q_not_full;
    logic             q_not_empty;
    t_vec             q_vec;
    logic             back_ready;

    assign pready = 1'b1;
    assign prdata = APB_DW'(r_zero_threshold);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_threshold <= THR_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[APB_AW-1] == REG_ZERO_THRESHOLD) begin
            r_zero_threshold <= pwdata[THR_W-1:0];
        end
    end

    pva_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_req       (i_req),
        .o_vec_valid (front_valid),
        .i_vec_ready (q_not_full),
        .o_vec       (front_vec)
    );

    pva_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (front_valid),
        .i_data      (front_vec),
        .o_not_full  (q_not_full),
        .i_rd        (back_ready),
        .o_not_empty (q_not_empty),
        .o_data      (q_vec)
    );

    pva_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_vec_valid (q_not_empty),
        .o_vec_ready (back_ready),
        .i_vec       (q_vec),
        .i_threshold (r_zero_threshold),
        .empty       (empty),
        .pop         (pop),
        .o_res       (o_res)
    );

endmodule
